// ----- rtl/core/hatt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hatt_pkg: shared types and constants for the heading angle unit
// Fixed-point formats, CORDIC arctangent table and special-case codes.
// ----------------------------------------------------------------------------
package hatt_pkg;

  // Default configuration
  localparam int unsigned DEF_CORDIC_STAGES = 20;
  localparam int unsigned DEF_COORD_WIDTH   = 24;

  // Datapath: vector scaled to 60 fraction-aligned bits, held in 64 bits
  localparam int unsigned VEC_W    = 64;
  localparam int unsigned VEC_TOP  = 60;
  // Angle accumulator: degrees with 20 fraction bits
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned YAW_W    = 17;
  localparam int unsigned ATAN_ENTRIES = 32;

  localparam logic signed [ACC_W-1:0] ANGLE_90   = 32'sd94371840;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 32'sd2048;
  localparam int unsigned             ROUND_SHIFT = 12;

  localparam logic signed [ACC_W-1:0] YAW_MAX_ACC = 32'sd46080;
  localparam logic signed [ACC_W-1:0] YAW_MIN_ACC = -32'sd46080;
  localparam logic signed [YAW_W-1:0] YAW_HALF_TURN = 17'sd46080;
  localparam logic signed [YAW_W-1:0] YAW_QUARTER   = 17'sd23040;

  // How the final angle is formed
  typedef enum logic [2:0] {
    KIND_CORDIC,
    KIND_DEGEN,
    KIND_ZERO,
    KIND_HALF_TURN,
    KIND_NEG_QUARTER,
    KIND_POS_QUARTER
  } yaw_kind_t;

  // round(atan(2^-i) * 180/pi * 2^20); zero past the last entry
  function automatic logic signed [ACC_W-1:0] atan_step(input int unsigned idx);
    case (idx)
      0:  return 32'sd47185920;
      1:  return 32'sd27855475;
      2:  return 32'sd14718068;
      3:  return 32'sd7471121;
      4:  return 32'sd3750058;
      5:  return 32'sd1876857;
      6:  return 32'sd938658;
      7:  return 32'sd469357;
      8:  return 32'sd234682;
      9:  return 32'sd117342;
      10: return 32'sd58671;
      11: return 32'sd29335;
      12: return 32'sd14668;
      13: return 32'sd7334;
      14: return 32'sd3667;
      15: return 32'sd1833;
      16: return 32'sd917;
      17: return 32'sd458;
      18: return 32'sd229;
      19: return 32'sd115;
      20: return 32'sd57;
      21: return 32'sd29;
      22: return 32'sd14;
      23: return 32'sd7;
      24: return 32'sd4;
      25: return 32'sd2;
      26: return 32'sd1;
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/heading_angle_to_target_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// heading_angle_to_target_top: yaw heading from own to target position
// Pipelined CORDIC vectoring unit giving atan2(-dz, dx) in degrees (8 frac).
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle; one register stage per CORDIC iteration,
// plus an input stage (difference, pre-rotation) and an output stage (round).
// busy is always low; results cannot be stalled and appear on done for one cycle.
// Reset clears the stage valid bits and done; items in flight are dropped.
module heading_angle_to_target_top
  import hatt_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int unsigned COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire signed [COORD_WIDTH-1:0]   own_x,
  input  wire signed [COORD_WIDTH-1:0]   own_z,
  input  wire signed [COORD_WIDTH-1:0]   target_x,
  input  wire signed [COORD_WIDTH-1:0]   target_z,
  output logic                           done,
  output logic signed [YAW_W-1:0]        yaw_angle,
  output logic                           degenerate
);

  localparam int unsigned NS        = CORDIC_STAGES;
  localparam int unsigned DIFF_W    = COORD_WIDTH + 1;
  localparam int unsigned GUARD_SH  = VEC_TOP - COORD_WIDTH;

  // Never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // Stage registers; index 0 is the input stage, index k after iteration k-1
  logic                    vld_q  [0:NS];
  yaw_kind_t               kind_q [0:NS];
  logic signed [VEC_W-1:0] x_q    [0:NS];
  logic signed [VEC_W-1:0] y_q    [0:NS];
  logic signed [ACC_W-1:0] acc_q  [0:NS];

  // Input stage: differences, special cases, scaling and pre-rotation
  logic signed [DIFF_W-1:0] dx, dz;
  logic signed [VEC_W-1:0]  xs0, ys0, x0_next, y0_next;
  logic signed [ACC_W-1:0]  acc0_next;
  yaw_kind_t                kind0_next;

  always_comb begin
    dx  = DIFF_W'(target_x) - DIFF_W'(own_x);
    dz  = DIFF_W'(target_z) - DIFF_W'(own_z);
    xs0 = VEC_W'(dx) <<< GUARD_SH;
    ys0 = -(VEC_W'(dz) <<< GUARD_SH);

    x0_next   = xs0;
    y0_next   = ys0;
    acc0_next = '0;
    if (xs0[VEC_W-1]) begin
      if (!ys0[VEC_W-1]) begin
        x0_next   = ys0;
        y0_next   = -xs0;
        acc0_next = ANGLE_90;
      end else begin
        x0_next   = -ys0;
        y0_next   = xs0;
        acc0_next = -ANGLE_90;
      end
    end

    if (dx == '0 && dz == '0) begin
      kind0_next = KIND_DEGEN;
    end else if (dz == '0) begin
      kind0_next = dx[DIFF_W-1] ? KIND_HALF_TURN : KIND_ZERO;
    end else if (dx == '0) begin
      kind0_next = dz[DIFF_W-1] ? KIND_POS_QUARTER : KIND_NEG_QUARTER;
    end else begin
      kind0_next = KIND_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
    kind_q[0] <= kind0_next;
    x_q[0]    <= x0_next;
    y_q[0]    <= y0_next;
    acc_q[0]  <= acc0_next;
  end

  // CORDIC iterations, one per register stage
  for (genvar gi = 0; gi < NS; gi++) begin : g_iter
    localparam int unsigned SH = gi;
    localparam logic signed [ACC_W-1:0] STEP =
      (SH < ATAN_ENTRIES) ? atan_step(SH) : '0;

    logic signed [VEC_W-1:0] xsh, ysh;
    assign xsh = x_q[gi] >>> SH;
    assign ysh = y_q[gi] >>> SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[gi+1] <= 1'b0;
      end else begin
        vld_q[gi+1] <= vld_q[gi];
      end
      kind_q[gi+1] <= kind_q[gi];
      if (!y_q[gi][VEC_W-1]) begin
        x_q[gi+1]   <= x_q[gi] + ysh;
        y_q[gi+1]   <= y_q[gi] - xsh;
        acc_q[gi+1] <= acc_q[gi] + STEP;
      end else begin
        x_q[gi+1]   <= x_q[gi] - ysh;
        y_q[gi+1]   <= y_q[gi] + xsh;
        acc_q[gi+1] <= acc_q[gi] - STEP;
      end
    end
  end

  // Output stage: round half up to 8 fraction bits, saturate, special cases
  logic signed [ACC_W-1:0] rounded;
  logic signed [YAW_W-1:0] yaw_next;

  always_comb begin
    rounded = (acc_q[NS] + ROUND_BIAS) >>> ROUND_SHIFT;
    if (rounded > YAW_MAX_ACC) begin
      rounded = YAW_MAX_ACC;
    end else if (rounded < YAW_MIN_ACC) begin
      rounded = YAW_MIN_ACC;
    end
    case (kind_q[NS])
      KIND_CORDIC:      yaw_next = rounded[YAW_W-1:0];
      KIND_HALF_TURN:   yaw_next = YAW_HALF_TURN;
      KIND_POS_QUARTER: yaw_next = YAW_QUARTER;
      KIND_NEG_QUARTER: yaw_next = -YAW_QUARTER;
      default:          yaw_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_q[NS];
    end
    yaw_angle  <= yaw_next;
    degenerate <= (kind_q[NS] == KIND_DEGEN);
  end

endmodule
`default_nettype wire
